// ===== rtl/bsm_pkg.sv =====
// bsm_pkg: shared types and constants for the bank switch mapper
// no dependencies; imported by bank_switch_mapper_with_scanline_irq_top
package bsm_pkg;

    // field widths
    localparam int OFS_W      = 22;
    localparam int BANK_OFS_W = 19;
    localparam int STEP_W     = 4;

    // result kinds
    localparam logic [1:0] KIND_PRG    = 2'd0;
    localparam logic [1:0] KIND_CHR    = 2'd1;
    localparam logic [1:0] KIND_MIRROR = 2'd2;
    localparam logic [1:0] KIND_IRQ    = 2'd3;

    // register pairs picked by address bits 14:13
    localparam logic [1:0] PAIR_BANK   = 2'd0;
    localparam logic [1:0] PAIR_MIRROR = 2'd1;
    localparam logic [1:0] PAIR_IRQ_LD = 2'd2;
    localparam logic [1:0] PAIR_IRQ_EN = 2'd3;

    // window sequence
    localparam logic [STEP_W-1:0] NUM_PRG_WIN = 4'd4;
    localparam logic [STEP_W-1:0] LAST_STEP   = 4'd11;

    // bank value masks and window increments
    localparam logic [7:0]       MASK_2K     = 8'hfe;
    localparam logic [7:0]       MASK_8K     = 8'h3f;
    localparam logic [2:0]       SEL_MASK    = 3'h7;
    localparam logic [OFS_W-1:0] INC_1K      = 22'h000400;
    localparam logic [OFS_W-1:0] INC_8K      = 22'h002000;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // one result item
    typedef struct packed {
        logic [1:0]       kind;
        logic [2:0]       window;
        logic [OFS_W-1:0] rom_offset;
        logic             mirror_horizontal;
        logic             irq_out;
        logic             last;
    } result_t;

endpackage

// ===== rtl/bank_switch_mapper_with_scanline_irq_top.sv =====
// bank_switch_mapper_with_scanline_irq_top: bank switch mapper with scanline irq counter
// depends on bsm_pkg
//
//  channel   signals                                     direction
//  in        in_valid/in_ready, mode, cpu_addr,          into block
//            write_data, irq_in
//  out       out_valid/out_ready, kind, window,          out of block
//            rom_offset, mirror_horizontal, irq_out, last
//  cfg       cfg_wr_en, cfg_wr_data (program size)       into block
//
// a bank write is accepted and updates state, then the 12-step sequencer gives one window
// per cycle through the shared offset adder while the output is not stalled
// every other item gives at most one result
// ready drops while the sequencer runs and while the output register is full
// and not being taken; a stall on the output holds the sequencer in place
// reset clears the control state and all mapper registers, program size to 2
module bank_switch_mapper_with_scanline_irq_top
    import bsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic [15:0]      cpu_addr,
    input  logic [7:0]       write_data,
    input  logic             irq_in,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [2:0]       window,
    output logic [OFS_W-1:0] rom_offset,
    output logic             mirror_horizontal,
    output logic             irq_out,
    output logic             last,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data
);

    state_t                state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [7:0]            units_reg;
    logic [BANK_OFS_W-1:0] bank_reg [8];
    logic [2:0]            sel_reg;
    logic                  prg_mode_reg;
    logic                  chr_mode_reg;
    logic [7:0]            reload_reg;
    logic [8:0]            irq_cnt_reg;
    logic                  irq_en_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  out_free;
    logic                  accept;
    logic [1:0]            pair;
    logic                  odd;
    logic [BANK_OFS_W-1:0] bank_wr_val;

    logic [2:0]            rd_idx;
    logic                  use_lastb;
    logic [OFS_W-1:0]      lastb;
    logic [OFS_W-1:0]      base;
    logic [OFS_W-1:0]      inc;
    logic [OFS_W-1:0]      win_sum;
    logic [2:0]            chr_j;
    logic                  chr_pair_half;
    logic                  tick_line;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign pair     = cpu_addr[14:13];
    assign odd      = cpu_addr[0];

    // value for a bank register write, by selected register
    always_comb
    begin
        if (sel_reg <= 3'd1)
            bank_wr_val = {1'b0, write_data & MASK_2K, 10'b0};
        else if (sel_reg >= 3'd6)
            bank_wr_val = BANK_OFS_W'({write_data & MASK_8K, 13'b0});
        else
            bank_wr_val = {1'b0, write_data, 10'b0};
    end

    // fixed last 16K unit of program rom
    assign lastb = {units_reg - 8'd1, 14'b0};

    // window base selection for the current step
    assign chr_j         = step_reg[2:0] - 3'd4;
    assign chr_pair_half = chr_j[2] ^ chr_mode_reg;

    always_comb
    begin
        rd_idx    = 3'd0;
        use_lastb = 1'b0;
        inc       = '0;
        if (step_reg < NUM_PRG_WIN)
        begin
            case (step_reg[1:0])
                2'd0:
                begin
                    use_lastb = prg_mode_reg;
                    rd_idx    = 3'd6;
                end
                2'd1:
                begin
                    rd_idx = 3'd7;
                end
                2'd2:
                begin
                    use_lastb = !prg_mode_reg;
                    rd_idx    = 3'd6;
                end
                default:
                begin
                    use_lastb = 1'b1;
                    inc       = INC_8K;
                end
            endcase
        end
        else if (!chr_pair_half)
        begin
            // 2K pair registers, upper 1K half on odd windows
            rd_idx = {2'b00, chr_j[1]};
            inc    = chr_j[0] ? INC_1K : '0;
        end
        else
        begin
            rd_idx = {1'b0, chr_j[1:0]} + 3'd2;
        end
    end

    // shared offset adder
    assign base    = use_lastb ? lastb : {3'b000, bank_reg[rd_idx]};
    assign win_sum = base + inc;

    // interrupt line on a tick
    assign tick_line = (irq_cnt_reg == 9'd0) ? (irq_in | irq_en_reg) : irq_in;

    // sequencer and output register next values
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        out_next       = '{KIND_IRQ, 3'd0, '0, 1'b0, tick_line, 1'b1};
                        out_valid_next = 1'b1;
                    end
                    else if (pair == PAIR_BANK)
                    begin
                        state_next = ST_EMIT;
                        step_next  = '0;
                    end
                    else if (pair == PAIR_MIRROR && !odd)
                    begin
                        out_next       = '{KIND_MIRROR, 3'd0, '0, write_data[0], 1'b0, 1'b1};
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.kind              = (step_reg < NUM_PRG_WIN) ? KIND_PRG : KIND_CHR;
                    out_next.window            = (step_reg < NUM_PRG_WIN) ? step_reg[2:0] : chr_j;
                    out_next.rom_offset        = win_sum;
                    out_next.mirror_horizontal = 1'b0;
                    out_next.irq_out           = 1'b0;
                    out_next.last              = (step_reg == LAST_STEP);
                    out_valid_next             = 1'b1;
                    step_next                  = step_reg + 4'd1;
                    if (step_reg == LAST_STEP)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // mapper state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg    <= 8'd2;
            for (int i = 0; i < 8; i++)
                bank_reg[i] <= '0;
            sel_reg      <= '0;
            prg_mode_reg <= 1'b0;
            chr_mode_reg <= 1'b0;
            reload_reg   <= '0;
            irq_cnt_reg  <= '0;
            irq_en_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                units_reg <= cfg_wr_data;
            if (accept)
            begin
                if (mode)
                begin
                    if (irq_cnt_reg == 9'd0)
                        irq_cnt_reg <= {1'b0, reload_reg};
                    else
                        irq_cnt_reg <= irq_cnt_reg - 9'd1;
                end
                else
                begin
                    unique case (pair)
                        PAIR_BANK:
                        begin
                            if (!odd)
                            begin
                                prg_mode_reg <= write_data[6];
                                chr_mode_reg <= write_data[7];
                                sel_reg      <= write_data[2:0] & SEL_MASK;
                            end
                            else
                            begin
                                bank_reg[sel_reg] <= bank_wr_val;
                            end
                        end
                        PAIR_MIRROR:
                        begin
                            // mirroring only goes to the output item
                        end
                        PAIR_IRQ_LD:
                        begin
                            if (!odd)
                                reload_reg <= write_data;
                            else
                                irq_cnt_reg <= {1'b0, reload_reg} + 9'd1;
                        end
                        PAIR_IRQ_EN:
                        begin
                            irq_en_reg <= odd;
                        end
                        default:
                        begin
                            irq_en_reg <= irq_en_reg;
                        end
                    endcase
                end
            end
        end
    end

    // output ports
    assign out_valid         = out_valid_reg;
    assign kind              = out_reg.kind;
    assign window            = out_reg.window;
    assign rom_offset        = out_reg.rom_offset;
    assign mirror_horizontal = out_reg.mirror_horizontal;
    assign irq_out           = out_reg.irq_out;
    assign last              = out_reg.last;

    // sequencer never runs past the last pattern window
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> step_reg <= LAST_STEP)
        else $error("window step out of range");

    // only the last pattern window of a bank write closes the item
    a_prg_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_PRG |-> !out_reg.last)
        else $error("program window marked last");

    a_chr_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_CHR |-> out_reg.last == (out_reg.window == 3'd7))
        else $error("pattern window last flag wrong");

    // reload plus one is the largest counter value
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        irq_cnt_reg <= 9'd256)
        else $error("irq counter out of range");

    // a stalled output holds the sequencer step
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !out_free |=> $stable(step_reg))
        else $error("sequencer advanced under stall");

endmodule
